@@ hw/rtl/ddo_pkg.sv @@
// ----------------------------------------------------------------------------
// ddo_pkg
// Types, constants and helpers shared by the odometry core and its units.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int unsigned CountWidthDefault  = 32;
  localparam int unsigned CordicStepsDefault = 16;
  localparam int unsigned AtanEntries        = 24;

  localparam int unsigned MulWidth  = 34;
  localparam int unsigned ProdWidth = 2 * MulWidth;

  localparam logic [23:0] MmPerCountReset = 24'd271791;
  localparam logic [23:0] InvWheelReset   = 24'd59663;
  localparam logic [15:0] SampleRateReset = 16'd250;

  localparam logic signed [20:0] PiQ16     = 21'sd205887;
  localparam logic signed [20:0] TwoPiQ16  = 21'sd411775;
  localparam logic signed [19:0] HalfPiQ16 = 20'sd102944;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  typedef enum logic [1:0] {
    REG_MM_PER_COUNT = 2'd0,
    REG_INV_WHEEL    = 2'd1,
    REG_SAMPLE_RATE  = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    OP_DR, OP_DL, OP_VR, OP_VL, OP_DTH, OP_LIN, OP_ANG, OP_PX, OP_PY
  } mul_op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DR, ST_DL, ST_VR, ST_VL, ST_DTH, ST_LIN, ST_ANG,
    ST_CWAIT, ST_PX, ST_PY, ST_DRAIN, ST_DONE
  } state_e;

  typedef struct packed {
    logic                       valid;
    mul_op_e                    op;
    logic signed [MulWidth-1:0] a;
    logic signed [MulWidth-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                        valid;
    mul_op_e                     op;
    logic signed [ProdWidth-1:0] prod;
  } mul_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [ProdWidth:0] v);
    logic signed [ProdWidth:0] hi;
    logic signed [ProdWidth:0] lo;
    hi = (ProdWidth+1)'(64'sd2147483647);
    lo = -(ProdWidth+1)'(64'sd2147483648);
    if (v > hi) return 32'sh7fffffff;
    if (v < lo) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [16:0] atan_q16(input logic [4:0] idx);
    case (idx)
      5'd0:  return 17'sd51472;
      5'd1:  return 17'sd30386;
      5'd2:  return 17'sd16055;
      5'd3:  return 17'sd8150;
      5'd4:  return 17'sd4091;
      5'd5:  return 17'sd2047;
      5'd6:  return 17'sd1024;
      5'd7:  return 17'sd512;
      5'd8:  return 17'sd256;
      5'd9:  return 17'sd128;
      5'd10: return 17'sd64;
      5'd11: return 17'sd32;
      5'd12: return 17'sd16;
      5'd13: return 17'sd8;
      5'd14: return 17'sd4;
      5'd15: return 17'sd2;
      5'd16: return 17'sd1;
      default: return 17'sd0;
    endcase
  endfunction

endpackage

@@ hw/rtl/ddo_mul.sv @@
// ----------------------------------------------------------------------------
// ddo_mul
// Shared signed multiplier, one registered product per cycle, op tag passed on.
// ----------------------------------------------------------------------------
module ddo_mul import ddo_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic                        valid_q;
  mul_op_e                     op_q;
  logic signed [ProdWidth-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      op_q   <= req_i.op;
      prod_q <= req_i.a * req_i.b;
    end
  end

  assign rsp_o.valid = valid_q;
  assign rsp_o.op    = op_q;
  assign rsp_o.prod  = prod_q;

endmodule

@@ hw/rtl/ddo_cordic.sv @@
// ----------------------------------------------------------------------------
// ddo_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle, gives cos and sin Q4.30.
// ----------------------------------------------------------------------------
module ddo_cordic import ddo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CordicStepsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [18:0] angle_i,
  output logic               done_o,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);

  localparam int unsigned NSteps = (CORDIC_STEPS > AtanEntries) ? AtanEntries : CORDIC_STEPS;

  logic signed [33:0] x_q, y_q;
  logic signed [19:0] z_q;
  logic               flip_q;
  logic [4:0]         cnt_q;
  logic               busy_q, done_q;

  logic signed [19:0] ang_ext, z_fold;
  logic               flip_d;
  logic signed [33:0] xs, ys;
  logic signed [19:0] at;

  always_comb begin
    ang_ext = 20'(angle_i);
    flip_d  = 1'b0;
    z_fold  = ang_ext;
    if (ang_ext > HalfPiQ16) begin
      z_fold = ang_ext - 20'(PiQ16);
      flip_d = 1'b1;
    end else if (ang_ext < -HalfPiQ16) begin
      z_fold = ang_ext + 20'(PiQ16);
      flip_d = 1'b1;
    end
    xs = x_q >>> cnt_q;
    ys = y_q >>> cnt_q;
    at = 20'(atan_q16(cnt_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'(NSteps - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CordicGain;
      y_q    <= '0;
      z_q    <= z_fold;
      flip_q <= flip_d;
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;

endmodule

@@ hw/rtl/differential_drive_odometry_core.sv @@
// ----------------------------------------------------------------------------
// differential_drive_odometry_core
// Wheel odometry: count deltas to pose and speeds via a shared multiplier and a CORDIC.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_ready_o   right_count_i, left_count_i
// out      output     out_valid_o/out_ready_i pose, heading, four speeds
// cfg      input      cfg_we_i                cfg_addr_i, cfg_wdata_i
//
// Each transaction waits on the CORDIC; nine products share one multiplier.
// in_ready_o is high only in idle; a pending result holds in output registers.
// Reset clears pose, previous counts and loads the default configuration.
// ----------------------------------------------------------------------------
module differential_drive_odometry_core import ddo_pkg::*; #(
  parameter int unsigned COUNT_WIDTH  = CountWidthDefault,
  parameter int unsigned CORDIC_STEPS = CordicStepsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] right_count_i,
  input  logic signed [31:0] left_count_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] x_position_o,
  output logic signed [31:0] y_position_o,
  output logic signed [18:0] heading_o,
  output logic signed [31:0] linear_speed_o,
  output logic signed [31:0] angular_speed_o,
  output logic signed [31:0] right_speed_o,
  output logic signed [31:0] left_speed_o
);

  state_e state_q, state_d;

  logic [23:0] mpc_q, iwb_q;
  logic [15:0] rate_q;

  logic [COUNT_WIDTH-1:0] prev_r_q, prev_l_q;
  logic signed [COUNT_WIDTH-1:0] diff_r, diff_l;
  logic signed [31:0] dcr_q, dcl_q;
  logic signed [31:0] dr_q, dl_q, vr_q, vl_q, lin_q, ang_q;
  logic signed [32:0] dth_q;
  logic signed [31:0] pose_x_q, pose_y_q;
  logic signed [18:0] pose_h_q;
  logic               out_valid_q;
  logic signed [31:0] x_o_q, y_o_q, lin_o_q, ang_o_q, vr_o_q, vl_o_q;
  logic signed [18:0] h_o_q;

  logic in_acc, out_free;
  mul_req_t req;
  mul_rsp_t rsp;
  logic               c_done;
  logic signed [33:0] c_cos, c_sin;

  logic signed [32:0] sum_d, dif_d;
  logic signed [ProdWidth-1:0] rnd16, rnd30;
  logic signed [ProdWidth:0]   pos_sum;
  logic signed [20:0] step, h_sum, h_new;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign diff_r   = right_count_i[COUNT_WIDTH-1:0] - prev_r_q;
  assign diff_l   = left_count_i[COUNT_WIDTH-1:0] - prev_l_q;
  assign sum_d    = 33'(dr_q) + 33'(dl_q);
  assign dif_d    = 33'(dr_q) - 33'(dl_q);

  ddo_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  ddo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .angle_i (pose_h_q),
    .done_o  (c_done),
    .cos_o   (c_cos),
    .sin_o   (c_sin)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_DR;
      ST_DR:    state_d = ST_DL;
      ST_DL:    state_d = ST_VR;
      ST_VR:    state_d = ST_VL;
      ST_VL:    state_d = ST_DTH;
      ST_DTH:   state_d = ST_LIN;
      ST_LIN:   state_d = ST_ANG;
      ST_ANG:   state_d = ST_CWAIT;
      ST_CWAIT: if (c_done) state_d = ST_PX;
      ST_PX:    state_d = ST_PY;
      ST_PY:    state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    req.valid  = 1'b1;
    req.op     = OP_DR;
    req.a      = '0;
    req.b      = '0;
    case (state_q)
      ST_DR: begin
        req.op = OP_DR;  req.a = 34'(dcr_q);  req.b = 34'($signed({1'b0, mpc_q}));
      end
      ST_DL: begin
        req.op = OP_DL;  req.a = 34'(dcl_q);  req.b = 34'($signed({1'b0, mpc_q}));
      end
      ST_VR: begin
        req.op = OP_VR;  req.a = 34'(dr_q);   req.b = 34'($signed({1'b0, rate_q}));
      end
      ST_VL: begin
        req.op = OP_VL;  req.a = 34'(dl_q);   req.b = 34'($signed({1'b0, rate_q}));
      end
      ST_DTH: begin
        req.op = OP_DTH; req.a = 34'(dif_d);  req.b = 34'($signed({1'b0, iwb_q}));
      end
      ST_LIN: begin
        req.op = OP_LIN; req.a = 34'(sum_d);  req.b = 34'($signed({1'b0, rate_q}));
      end
      ST_ANG: begin
        req.op = OP_ANG; req.a = 34'(dth_q);  req.b = 34'($signed({1'b0, rate_q}));
      end
      ST_PX: begin
        req.op = OP_PX;  req.a = 34'($signed(sum_d[32:1])); req.b = c_cos;
      end
      ST_PY: begin
        req.op = OP_PY;  req.a = 34'($signed(sum_d[32:1])); req.b = c_sin;
      end
      default: req.valid = 1'b0;
    endcase
  end

  always_comb begin
    rnd16   = (rsp.prod + ProdWidth'(64'sd32768)) >>> 16;
    rnd30   = (rsp.prod + ProdWidth'(64'sd536870912)) >>> 30;
    pos_sum = (ProdWidth+1)'(rnd30) +
              (ProdWidth+1)'((rsp.op == OP_PX) ? pose_x_q : pose_y_q);
    step = 21'(dth_q);
    if (dth_q > 33'(PiQ16)) step = PiQ16;
    if (dth_q < -33'(PiQ16)) step = -PiQ16;
    h_sum = 21'(pose_h_q) + step;
    h_new = h_sum;
    if (h_sum > PiQ16) h_new = h_sum - TwoPiQ16;
    if (h_sum < -PiQ16) h_new = h_sum + TwoPiQ16;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      mpc_q       <= MmPerCountReset;
      iwb_q       <= InvWheelReset;
      rate_q      <= SampleRateReset;
      prev_r_q    <= '0;
      prev_l_q    <= '0;
      pose_x_q    <= '0;
      pose_y_q    <= '0;
      pose_h_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_MM_PER_COUNT: mpc_q  <= cfg_wdata_i;
          REG_INV_WHEEL:    iwb_q  <= cfg_wdata_i;
          REG_SAMPLE_RATE:  rate_q <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        prev_r_q <= right_count_i[COUNT_WIDTH-1:0];
        prev_l_q <= left_count_i[COUNT_WIDTH-1:0];
      end
      if (rsp.valid && rsp.op == OP_PX) pose_x_q <= sat32(pos_sum);
      if (rsp.valid && rsp.op == OP_PY) pose_y_q <= sat32(pos_sum);
      if (state_q == ST_DRAIN) pose_h_q <= h_new[18:0];
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dcr_q <= 32'(diff_r);
      dcl_q <= 32'(diff_l);
    end
    if (rsp.valid) begin
      case (rsp.op)
        OP_DR:  dr_q  <= sat32((ProdWidth+1)'(rnd16));
        OP_DL:  dl_q  <= sat32(-(ProdWidth+1)'(rnd16));
        OP_VR:  vr_q  <= sat32((ProdWidth+1)'(rsp.prod));
        OP_VL:  vl_q  <= sat32((ProdWidth+1)'(rsp.prod));
        OP_LIN: lin_q <= sat32((ProdWidth+1)'(rsp.prod >>> 1));
        OP_ANG: ang_q <= sat32((ProdWidth+1)'(rsp.prod));
        OP_DTH: begin
          if (rnd16 > ProdWidth'(64'sd4294967295)) dth_q <= 33'sh0ffffffff;
          else if (rnd16 < -ProdWidth'(64'sd4294967296)) dth_q <= 33'sh100000000;
          else dth_q <= rnd16[32:0];
        end
        default: ;
      endcase
    end
    if (state_q == ST_DONE && out_free) begin
      x_o_q   <= pose_x_q;
      y_o_q   <= pose_y_q;
      h_o_q   <= pose_h_q;
      lin_o_q <= lin_q;
      ang_o_q <= ang_q;
      vr_o_q  <= vr_q;
      vl_o_q  <= vl_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign x_position_o    = x_o_q;
  assign y_position_o    = y_o_q;
  assign heading_o       = h_o_q;
  assign linear_speed_o  = lin_o_q;
  assign angular_speed_o = ang_o_q;
  assign right_speed_o   = vr_o_q;
  assign left_speed_o    = vl_o_q;

endmodule

@@ hw/rtl/ddo_chk.sv @@
// ----------------------------------------------------------------------------
// ddo_chk
// Port-level checks on the odometry core, bound to the top level.
// ----------------------------------------------------------------------------
module ddo_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] x_position_o,
  input logic signed [18:0] heading_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready after accept");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result while idle");

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> heading_o <= 19'sd205887 && heading_o >= -19'sd205887)
    else $error("heading out of range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(x_position_o))
    else $error("result dropped");

endmodule

bind differential_drive_odometry_core ddo_chk u_ddo_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .x_position_o (x_position_o),
  .heading_o    (heading_o)
);
